// ===== hw/rtl/ttdp_pkg.sv =====
package ttdp_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ATAN_IDX_W       = 5;

    // Q4.12 pi and Q.24 half pi
    localparam logic signed [18:0] PI_Q12      = 19'sd12868;
    localparam logic signed [18:0] TWO_PI_Q12  = 19'sd25736;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic [15:0]        INV_GAIN_Q16 = 16'd39797;

    localparam logic [1:0] OP_POSE = 2'd0;
    localparam logic [1:0] OP_GOAL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] CFG_ANG_GAIN  = 3'd0;
    localparam logic [2:0] CFG_LIN_GAIN  = 3'd1;
    localparam logic [2:0] CFG_DIST_THR  = 3'd2;
    localparam logic [2:0] CFG_AIM_THR   = 3'd3;
    localparam logic [2:0] CFG_FINAL_THR = 3'd4;

    localparam int VEC_W = 37;   // CORDIC x/y width
    localparam int ANG_W = 28;   // CORDIC angle, Q.24

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
        logic               waypoint_active;
    } t_out_rsp;

    typedef struct packed {
        logic                    done;
        logic signed [VEC_W-1:0] x;
        logic signed [ANG_W-1:0] z;
    } t_cordic_res;

    function automatic logic [23:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/ttdp_mult.sv =====
module ttdp_mult (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [37:0] i_a,
    input  logic signed [16:0] i_b,
    output logic signed [54:0] o_p
);
    logic signed [54:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule

// ===== hw/rtl/ttdp_cordic.sv =====
module ttdp_cordic #(
    parameter int CORDIC_STEPS = ttdp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [32:0]    i_dx,
    input  logic signed [32:0]    i_dy,
    output ttdp_pkg::t_cordic_res o_res
);
    localparam int STEPS = (CORDIC_STEPS > ttdp_pkg::TABLE_LEN) ?
                           ttdp_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int CW = $clog2(STEPS);
    localparam int VW = ttdp_pkg::VEC_W;
    localparam int AW = ttdp_pkg::ANG_W;

    logic signed [VW-1:0] r_x, r_y, n_x, n_y, xs, ys, x0, y0;
    logic signed [AW-1:0] r_z, n_z, at;
    logic [CW-1:0]        r_i;
    logic                 r_busy, r_done;

    assign x0 = VW'(i_dx);
    assign y0 = VW'(i_dy);
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = AW'($signed({1'b0,
                ttdp_pkg::atan_q24(ttdp_pkg::ATAN_IDX_W'(r_i))}));

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (i_start) begin
            n_x = x0;
            n_y = y0;
            n_z = '0;
            // quarter turn first so the micro-rotations converge
            if (i_dx < 0) begin
                if (i_dy >= 0) begin
                    n_x = y0;
                    n_y = -x0;
                    n_z = ttdp_pkg::HALF_PI_Q24;
                end else begin
                    n_x = -y0;
                    n_y = x0;
                    n_z = -ttdp_pkg::HALF_PI_Q24;
                end
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + at;
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.x    = r_x;
    assign o_res.z    = r_z;
endmodule

// ===== hw/rtl/turn_then_drive_pose_controller.sv =====
// Channel  | Direction | Handshake               | Payload
// in       | input     | i_in_valid / o_in_stall | i_in_req (ttdp_pkg::t_in_req)
// out      | output    | o_out_valid / i_out_stall | o_out_rsp (ttdp_pkg::t_out_rsp)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Pose and goal requests are taken while idle. A control tick, once a goal has been
// seen, stalls the input until its result is registered, and it passes through these steps:
// CORDIC_STEPS vectoring steps (capped at TABLE_LEN), one step to see the CORDIC finish, two passes through the
// shared multiplier with a distance step between them, and the result step.
// Synchronous active-low reset clears pose, goal and flags, and loads the
// default gains and thresholds. A stalled result is held in the output
// register; the next tick waits in its last step only while that is occupied.
module turn_then_drive_pose_controller #(
    parameter int CORDIC_STEPS = ttdp_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ttdp_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ttdp_pkg::t_out_rsp o_out_rsp,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORD = 3'd1;
    localparam logic [2:0] S_DMUL = 3'd2;
    localparam logic [2:0] S_DIST = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0]         r_state;
    logic signed [31:0] r_rx, r_ry, r_gx, r_gy;
    logic signed [15:0] r_ryaw, r_gyaw;
    logic               r_pend, r_seen;
    logic [15:0]        r_ang_gain, r_lin_gain, r_dist_thr;
    logic [14:0]        r_aim_thr, r_fin_thr;
    logic               r_zero;
    logic signed [16:0] r_bear;
    logic [35:0]        r_dist;
    logic               r_rot, r_drv, r_fin_ok;
    ttdp_pkg::t_out_rsp r_out;
    logic               r_out_valid;

    logic               in_acc, tick_go, out_free;
    logic signed [32:0] dx, dy;
    ttdp_pkg::t_cordic_res cres;
    logic               mul_en;
    logic signed [37:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [54:0] prod;

    logic signed [27:0] zr;
    logic signed [16:0] ferr, absf;
    logic signed [18:0] berr0, berr1, berr, aimed, absa;
    logic               near, rot, drv;
    logic [54:0]        dsum;
    logic signed [54:0] lsum, asum;
    logic signed [38:0] aq;
    logic signed [15:0] lin_sat, ang_sat;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign tick_go    = in_acc && (i_in_req.opcode == ttdp_pkg::OP_TICK) && r_seen;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign dx = 33'(r_gx) - 33'(r_rx);
    assign dy = 33'(r_gy) - 33'(r_ry);

    ttdp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tick_go),
        .i_dx    (dx),
        .i_dy    (dy),
        .o_res   (cres)
    );

    ttdp_mult u_mult (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // decision arithmetic
    assign zr    = cres.z + 28'sd2048;
    assign ferr  = 17'(r_gyaw) - 17'(r_ryaw);
    assign absf  = (ferr < 0) ? -ferr : ferr;
    assign berr0 = 19'(r_bear) - 19'(r_ryaw);
    assign berr1 = (berr0 > ttdp_pkg::PI_Q12) ? berr0 - ttdp_pkg::TWO_PI_Q12 : berr0;
    assign berr  = (berr1 < -ttdp_pkg::PI_Q12) ? berr1 + ttdp_pkg::TWO_PI_Q12 : berr1;
    assign near  = r_dist < {20'd0, r_dist_thr};
    assign aimed = near ? 19'(ferr) : berr;
    assign absa  = (aimed < 0) ? -aimed : aimed;
    assign rot   = r_pend && (absa > $signed({4'd0, r_aim_thr}));
    assign drv   = r_pend && !near && !rot;

    always_comb begin
        mul_en = 1'b0;
        mul_a  = $signed({1'b0, cres.x});
        mul_b  = $signed({1'b0, ttdp_pkg::INV_GAIN_Q16});
        if (r_state == S_DMUL) begin
            mul_en = 1'b1;
        end else if (r_state == S_DEC) begin
            mul_en = 1'b1;
            if (rot) begin
                mul_a = 38'(aimed);
                mul_b = $signed({1'b0, r_ang_gain});
            end else begin
                mul_a = $signed({2'b0, r_dist});
                mul_b = $signed({1'b0, r_lin_gain});
            end
        end
    end

    assign dsum = prod + 55'sd32768;
    assign lsum = prod + 55'sd524288;
    assign asum = prod + 55'sd32768;
    assign aq   = 39'(asum >>> 16);

    assign lin_sat = (lsum[54:20] > 35'd32767) ? 16'sd32767 : $signed(lsum[35:20]);
    assign ang_sat = (aq > 39'sd32767)  ? 16'sd32767 :
                     (aq < -39'sd32768) ? -16'sd32768 : aq[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rx        <= '0;
            r_ry        <= '0;
            r_ryaw      <= '0;
            r_gx        <= '0;
            r_gy        <= '0;
            r_gyaw      <= '0;
            r_pend      <= 1'b0;
            r_seen      <= 1'b0;
            r_ang_gain  <= 16'd22938;
            r_lin_gain  <= 16'd42598;
            r_dist_thr  <= 16'd6554;
            r_aim_thr   <= 15'd614;
            r_fin_thr   <= 15'd410;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_RES && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ttdp_pkg::CFG_ANG_GAIN:  r_ang_gain <= i_cfg_data;
                    ttdp_pkg::CFG_LIN_GAIN:  r_lin_gain <= i_cfg_data;
                    ttdp_pkg::CFG_DIST_THR:  r_dist_thr <= i_cfg_data;
                    ttdp_pkg::CFG_AIM_THR:   r_aim_thr  <= i_cfg_data[14:0];
                    ttdp_pkg::CFG_FINAL_THR: r_fin_thr  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_req.opcode)
                            ttdp_pkg::OP_POSE: begin
                                r_rx   <= i_in_req.pos_x;
                                r_ry   <= i_in_req.pos_y;
                                r_ryaw <= i_in_req.heading;
                            end
                            ttdp_pkg::OP_GOAL: begin
                                r_gx   <= i_in_req.pos_x;
                                r_gy   <= i_in_req.pos_y;
                                r_gyaw <= i_in_req.heading;
                                r_pend <= 1'b1;
                                r_seen <= 1'b1;
                            end
                            default: ;
                        endcase
                        if (tick_go) begin
                            r_state <= S_CORD;
                        end
                    end
                end
                S_CORD: if (cres.done) r_state <= S_DMUL;
                S_DMUL: r_state <= S_DIST;
                S_DIST: r_state <= S_DEC;
                S_DEC:  r_state <= S_RES;
                S_RES: begin
                    if (out_free) begin
                        if (r_fin_ok) begin
                            r_pend <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_zero <= (dx == 33'sd0) && (dy == 33'sd0);
        end
        if (r_state == S_CORD && cres.done) begin
            r_bear <= r_zero ? 17'sd0 : 17'($signed(zr[27:12]));
        end
        if (r_state == S_DIST) begin
            r_dist <= r_zero ? 36'd0 : dsum[51:16];
        end
        if (r_state == S_DEC) begin
            r_rot <= rot;
            r_drv <= drv;
            // an idle or arrived robot counts as near
            r_fin_ok <= (near || !(rot || drv)) &&
                        (absf < $signed({2'b0, r_fin_thr}));
        end
        if (r_state == S_RES && out_free) begin
            r_out.linear_velocity  <= r_drv ? lin_sat : 16'sd0;
            r_out.angular_velocity <= r_rot ? ang_sat : 16'sd0;
            r_out.waypoint_active  <= r_pend && !r_fin_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

`ifndef SYNTHESIS
    a_done_in_cord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cres.done |-> (r_state == S_CORD))
        else $error("CORDIC finished outside its wait step");
    a_rsp_from_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_RES))
        else $error("result raised without a finished tick");
    a_active_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.waypoint_active) |-> r_seen)
        else $error("active waypoint before any goal");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) |-> !(r_rot && r_drv))
        else $error("turn and drive chosen together");
`endif
endmodule
